FILE: rtl/fsts_pkg.sv
// fsts_pkg: shared constants, request and status codes and the control struct
// for the four-slot thread scheduler
// no dependencies
package fsts_pkg;

  // default configuration
  localparam int SLOTS_DEF        = 4;
  localparam int STACK_STRIDE_DEF = 16;

  // stack layout
  localparam logic [7:0] STACK_BASE0 = 8'h3F;
  localparam logic [7:0] FRAME_BYTES = 8'd7;

  // request codes
  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_YIELD  = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_EXIT   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic exec;   // run the accepted request and load the result register
  } cmd_t;

endpackage

FILE: rtl/fsts_if.sv
// fsts_req_if / fsts_rsp_if: valid-ready channels for requests and results
// no dependencies
interface fsts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] cur_sp;

  modport source (output valid, output req_type, output cur_sp, input ready);
  modport sink   (input valid, input req_type, input cur_sp, output ready);
endinterface

interface fsts_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] thread_id;
  logic [7:0] stack_ptr;
  logic [1:0] bank_select;
  logic [1:0] status;
  logic [3:0] alive_map;

  modport source (output valid, output thread_id, output stack_ptr,
                  output bank_select, output status, output alive_map,
                  input ready);
  modport sink   (input valid, input thread_id, input stack_ptr,
                  input bank_select, input status, input alive_map,
                  output ready);
endinterface

FILE: rtl/fsts_ctrl.sv
// fsts_ctrl: handshake controller, tracks whether the result register holds a beat
// depends on fsts_pkg
module fsts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output fsts_pkg::cmd_t cmd
);
  import fsts_pkg::*;

  localparam logic S_EMPTY = 1'b0;
  localparam logic S_FULL  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  // take a new beat when the result register is empty or drains this cycle
  assign in_ready  = (state_r == S_EMPTY) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state_r == S_FULL);
  assign cmd.exec  = accept;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_EMPTY: begin
        if (accept) state_nxt = S_FULL;
      end
      S_FULL: begin
        if (accept)         state_nxt = S_FULL;
        else if (out_ready) state_nxt = S_EMPTY;
      end
      default: state_nxt = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_EMPTY;
    else        state_r <= state_nxt;
  end

  // an accepted beat always shows up as a result next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid) else $error("accepted beat produced no result");

  // a stalled, held result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("input taken over held result");

  // a result not taken stays valid
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("held result dropped");

endmodule

FILE: rtl/fsts_dp.sv
// fsts_dp: scheduler state (live map, running slot, saved stack pointers)
// and the registered result; depends on fsts_pkg
module fsts_dp #(
  parameter int SLOTS        = fsts_pkg::SLOTS_DEF,
  parameter int STACK_STRIDE = fsts_pkg::STACK_STRIDE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fsts_pkg::cmd_t cmd,
  input  logic [1:0]     req_type,
  input  logic [7:0]     cur_sp,
  output logic [1:0]     thread_id,
  output logic [7:0]     stack_ptr,
  output logic [1:0]     bank_select,
  output logic [1:0]     status,
  output logic [3:0]     alive_map
);
  import fsts_pkg::*;

  localparam int SW = $clog2(SLOTS);

  // scheduler state
  logic [SLOTS-1:0] live_r;
  logic [SLOTS-1:0] live_nxt;
  logic [SW-1:0]    run_r;
  logic [SW-1:0]    run_nxt;
  logic [7:0]       stack_r [SLOTS];

  // result register
  logic [1:0]       tid_r;
  logic [7:0]       sp_r;
  logic [1:0]       status_r;
  logic [3:0]       alive_r;

  logic             wr_en;
  logic [SW-1:0]    wr_idx;
  logic [7:0]       wr_val;
  logic [SW-1:0]    id;
  logic [1:0]       st;
  logic [7:0]       sp_out;
  logic [SW-1:0]    free_idx;
  logic [SLOTS-1:0] clr_mask;
  logic [SLOTS-1:0] live_left;
  logic [SW+1:0]    id_ext;
  logic [SLOTS+3:0] live_ext;

  // stack base of a slot, wraps within 8 bits
  function automatic logic [7:0] slot_base(input logic [SW-1:0] s);
    slot_base = 8'(int'(STACK_BASE0) + int'(s) * STACK_STRIDE);
  endfunction

  // first live slot in the order 1, 2, ..., SLOTS-1, 0
  function automatic logic [SW-1:0] pick_fixed(input logic [SLOTS-1:0] m,
                                               input logic [SW-1:0]    dflt);
    logic [SW-1:0] p;
    p = dflt;
    if (m[0]) p = '0;
    for (int k = SLOTS - 1; k >= 1; k--) begin
      if (m[k]) p = SW'(k);
    end
    pick_fixed = p;
  endfunction

  // next live slot after the running one, wrapping round
  function automatic logic [SW-1:0] pick_next(input logic [SLOTS-1:0] m,
                                              input logic [SW-1:0]    cur);
    logic [SW-1:0] p;
    logic [SW:0]   idx;
    p = cur;
    for (int k = SLOTS; k >= 1; k--) begin
      idx = {1'b0, cur} + (SW+1)'(k);
      if (idx >= (SW+1)'(SLOTS)) idx = idx - (SW+1)'(SLOTS);
      if (m[idx[SW-1:0]]) p = idx[SW-1:0];
    end
    pick_next = p;
  endfunction

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!live_r[k]) free_idx = SW'(k);
    end
  end

  // live map with the running slot removed
  always_comb begin
    clr_mask        = '0;
    clr_mask[run_r] = 1'b1;
    live_left       = live_r & ~clr_mask;
  end

  // request decode and next state
  always_comb begin
    live_nxt = live_r;
    run_nxt  = run_r;
    wr_en    = 1'b0;
    wr_idx   = run_r;
    wr_val   = cur_sp;
    id       = run_r;
    st       = ST_OK;
    case (req_type)
      REQ_CREATE: begin
        if (&live_r) begin
          st = ST_FULL;
        end else begin
          if (live_r == '0) run_nxt = free_idx;
          live_nxt[free_idx] = 1'b1;
          wr_en  = 1'b1;
          wr_idx = free_idx;
          wr_val = slot_base(free_idx) + FRAME_BYTES;
          id     = free_idx;
        end
      end
      REQ_YIELD, REQ_TICK: begin
        if (live_r == '0) begin
          st = ST_NONE;
        end else begin
          wr_en   = 1'b1;
          run_nxt = (req_type == REQ_YIELD) ? pick_fixed(live_r, run_r)
                                            : pick_next(live_r, run_r);
          id      = run_nxt;
        end
      end
      REQ_EXIT: begin
        if (live_r == '0) begin
          st = ST_NONE;
        end else begin
          live_nxt = live_left;
          wr_en    = 1'b1;
          wr_val   = slot_base(run_r);
          if (live_left == '0) st = ST_NONE;
          else                 run_nxt = pick_fixed(live_left, run_r);
          id = run_nxt;
        end
      end
      default: st = ST_OK;
    endcase
  end

  // saved pointer of the reported slot, forwarding this beat's write
  always_comb begin
    sp_out = (wr_en && (id == wr_idx)) ? wr_val : stack_r[id];
  end

  // fixed-width result fields
  always_comb begin
    id_ext   = (SW+2)'(id);
    live_ext = (SLOTS+4)'(live_nxt);
  end

  // scheduler state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      run_r  <= '0;
      for (int i = 0; i < SLOTS; i++) stack_r[i] <= slot_base(SW'(i));
    end else if (cmd.exec) begin
      live_r <= live_nxt;
      run_r  <= run_nxt;
      if (wr_en) stack_r[wr_idx] <= wr_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      tid_r    <= id_ext[1:0];
      sp_r     <= sp_out;
      status_r <= st;
      alive_r  <= live_ext[3:0];
    end
  end

  assign thread_id   = tid_r;
  assign bank_select = tid_r;
  assign stack_ptr   = sp_r;
  assign status      = status_r;
  assign alive_map   = alive_r;

endmodule

FILE: rtl/four_slot_thread_scheduler.sv
// four_slot_thread_scheduler: top level, joins controller and datapath
// depends on fsts_pkg, fsts_if, fsts_ctrl, fsts_dp
//
// Usage:
// - in_req carries one request beat: req_type (create, yield, timer tick,
//   exit) and cur_sp, the stack pointer of the running thread.
// - out_rsp returns exactly one result beat per request: the slot id, its
//   saved stack pointer, its register bank, a status code and the live map.
// - The result is registered: a beat accepted at one edge shows up as a valid
//   result after that edge. Throughput is one request per cycle while results
//   are taken; the whole decision (lowest free slot, priority pick, rotation)
//   settles in the single combinational step in front of the result register.
// - When the receiver stalls, the result register holds its beat and in_req
//   is not ready until that beat is taken; a beat can enter in the same
//   cycle that the held one leaves.
// - Reset (rst_n low, synchronous) clears the live map, sets the running
//   slot to zero, loads every saved pointer with its slot's stack base and
//   empties the result register.
module four_slot_thread_scheduler #(
  parameter int SLOTS        = fsts_pkg::SLOTS_DEF,
  parameter int STACK_STRIDE = fsts_pkg::STACK_STRIDE_DEF
) (
  input logic         clk,
  input logic         rst_n,
  fsts_req_if.sink    in_req,
  fsts_rsp_if.source  out_rsp
);
  import fsts_pkg::*;

  cmd_t cmd;

  // handshake control
  fsts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  // scheduler state and result register
  fsts_dp #(
    .SLOTS        (SLOTS),
    .STACK_STRIDE (STACK_STRIDE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .req_type    (in_req.req_type),
    .cur_sp      (in_req.cur_sp),
    .thread_id   (out_rsp.thread_id),
    .stack_ptr   (out_rsp.stack_ptr),
    .bank_select (out_rsp.bank_select),
    .status      (out_rsp.status),
    .alive_map   (out_rsp.alive_map)
  );

endmodule
